FILE: rtl/hcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg: shared constants for the huffman code builder
// field widths of input and result words and the default leaf count
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int MAX_LEAVES_DEF = 32;
    localparam int WEIGHT_W       = 16;
    localparam int NODE_WEIGHT_W  = 21;
    localparam int CODE_W         = 31;
    localparam int LEN_W          = 5;

endpackage

FILE: rtl/hcb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_ram: generic simple dual port ram
// one write port, one read port with registered read data, no reset
// ----------------------------------------------------------------------------
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/huffman_code_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder_unit: huffman code construction over a weight set
// build: weights are stored while idle; a merge scans the roots for the two lightest,
// writes the parent, compacts the list and appends the parent (one forest read port)
// walk: root read and push, then per node a pop and node read, child pushes, code emit
// throughput: one set at a time; weight_stall is high while building/walking
// reset: rst_n async active low clears sequencer, counts and output valid; rams not cleared
// ----------------------------------------------------------------------------
module huffman_code_builder_unit
    import hcb_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                weight_valid,
    output logic                weight_stall,
    input  logic [WEIGHT_W-1:0] symbol_weight,
    input  logic                last_weight,
    output logic                code_valid,
    input  logic                code_stall,
    output logic [WEIGHT_W-1:0] leaf_weight,
    output logic [CODE_W-1:0]   code_bits,
    output logic [LEN_W-1:0]    code_length,
    output logic                last_code
);

    localparam int NW      = NODE_WEIGHT_W;
    localparam int NDEPTH  = 2 * MAX_LEAVES - 1;
    localparam int NIW     = $clog2(NDEPTH);
    localparam int NCW     = $clog2(2 * MAX_LEAVES);
    localparam int FCW     = $clog2(MAX_LEAVES + 1);
    localparam int FAW     = $clog2(MAX_LEAVES);
    localparam int SDEPTH  = 2 * MAX_LEAVES;
    localparam int SAW     = $clog2(SDEPTH);
    localparam int SPW     = SAW + 1;
    localparam int NODE_DW = NW + 2 * NIW + 1;
    localparam int FOR_DW  = NW + NIW;
    localparam int STK_DW  = NIW + CODE_W + LEN_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CODE_W);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_SCAN_RD  = 14'b00000000000010,
        S_SCAN_USE = 14'b00000000000100,
        S_MERGE_WR = 14'b00000000001000,
        S_COMP_RD  = 14'b00000000010000,
        S_COMP_USE = 14'b00000000100000,
        S_COMP_END = 14'b00000001000000,
        S_ROOT_RD  = 14'b00000010000000,
        S_ROOT_USE = 14'b00000100000000,
        S_POP_RD   = 14'b00001000000000,
        S_POP_USE  = 14'b00010000000000,
        S_NODE_USE = 14'b00100000000000,
        S_EMIT     = 14'b01000000000000,
        S_PUSH_R   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   push_l_reg, push_l_next;

    logic [FCW-1:0]    cnt_reg, cnt_next;
    logic [NCW-1:0]    nc_reg, nc_next;
    logic [FCW-1:0]    i_reg, i_next;
    logic [FCW-1:0]    j_reg, j_next;
    logic [NW-1:0]     wa_reg, wa_next, wb_reg, wb_next;
    logic [NIW-1:0]    na_reg, na_next, nb_reg, nb_next;
    logic [FCW-1:0]    pa_reg, pa_next, pb_reg, pb_next;
    logic [NW-1:0]     psum_reg, psum_next;
    logic [NIW-1:0]    pid_reg, pid_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [CODE_W-1:0] cur_code_reg, cur_code_next;
    logic [LEN_W-1:0]  cur_len_reg, cur_len_next;
    logic [NIW-1:0]    cur_left_reg, cur_left_next;
    logic [NIW-1:0]    cur_right_reg, cur_right_next;
    logic [WEIGHT_W-1:0] cur_w_reg, cur_w_next;

    logic                ov_reg, ov_next;
    logic [WEIGHT_W-1:0] ow_reg, ow_next;
    logic [CODE_W-1:0]   oc_reg, oc_next;
    logic [LEN_W-1:0]    ol_reg, ol_next;
    logic                olast_reg, olast_next;

    // ram ports
    logic               n_we;
    logic [NIW-1:0]     n_waddr, n_raddr;
    logic [NODE_DW-1:0] n_wdata, n_rdata;
    logic               f_we;
    logic [FAW-1:0]     f_waddr, f_raddr;
    logic [FOR_DW-1:0]  f_wdata, f_rdata;
    logic               s_we;
    logic [SAW-1:0]     s_waddr, s_raddr;
    logic [STK_DW-1:0]  s_wdata, s_rdata;

    // decoded read words
    logic [NW-1:0]     fr_w;
    logic [NIW-1:0]    fr_n;
    logic [NIW-1:0]    sr_node;
    logic [CODE_W-1:0] sr_code;
    logic [LEN_W-1:0]  sr_len;
    logic              nr_leaf;
    logic [SPW:0]      sp_plus2;

    assign fr_w    = f_rdata[FOR_DW-1 -: NW];
    assign fr_n    = f_rdata[NIW-1:0];
    assign sr_node = s_rdata[STK_DW-1 -: NIW];
    assign sr_code = s_rdata[LEN_W +: CODE_W];
    assign sr_len  = s_rdata[LEN_W-1:0];
    assign nr_leaf = n_rdata[0];
    assign sp_plus2 = {1'b0, sp_reg} + (SPW+1)'(2);

    // node store
    hcb_ram #(.WIDTH(NODE_DW), .DEPTH(NDEPTH)) u_node_ram (
        .clk(clk), .wr_en(n_we), .wr_addr(n_waddr), .wr_data(n_wdata),
        .rd_addr(n_raddr), .rd_data(n_rdata)
    );

    // forest list: root weight and node id per position
    hcb_ram #(.WIDTH(FOR_DW), .DEPTH(MAX_LEAVES)) u_forest_ram (
        .clk(clk), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
        .rd_addr(f_raddr), .rd_data(f_rdata)
    );

    // depth-first walk stack
    hcb_ram #(.WIDTH(STK_DW), .DEPTH(SDEPTH)) u_stack_ram (
        .clk(clk), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
        .rd_addr(s_raddr), .rd_data(s_rdata)
    );

    assign weight_stall = (state_reg != S_IDLE);
    assign code_valid   = ov_reg;
    assign leaf_weight  = ow_reg;
    assign code_bits    = oc_reg;
    assign code_length  = ol_reg;
    assign last_code    = olast_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        push_l_next    = push_l_reg;
        cnt_next       = cnt_reg;
        nc_next        = nc_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        psum_next      = psum_reg;
        pid_next       = pid_reg;
        sp_next        = sp_reg;
        cur_code_next  = cur_code_reg;
        cur_len_next   = cur_len_reg;
        cur_left_next  = cur_left_reg;
        cur_right_next = cur_right_reg;
        cur_w_next     = cur_w_reg;
        ov_next        = ov_reg & code_stall;
        ow_next        = ow_reg;
        oc_next        = oc_reg;
        ol_next        = ol_reg;
        olast_next     = olast_reg;

        n_we    = 1'b0;
        n_waddr = nc_reg[NIW-1:0];
        n_wdata = '0;
        n_raddr = sr_node;
        f_we    = 1'b0;
        f_waddr = cnt_reg[FAW-1:0];
        f_wdata = '0;
        f_raddr = i_reg[FAW-1:0];
        s_we    = 1'b0;
        s_waddr = sp_reg[SAW-1:0];
        s_wdata = '0;
        s_raddr = SAW'(sp_reg - SPW'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (weight_valid)
                begin
                    // store the leaf unless the set is full
                    if (cnt_reg < FCW'(MAX_LEAVES))
                    begin
                        n_we     = 1'b1;
                        n_wdata  = {NW'(symbol_weight), {NIW{1'b0}}, {NIW{1'b0}}, 1'b1};
                        f_we     = 1'b1;
                        f_wdata  = {NW'(symbol_weight), nc_reg[NIW-1:0]};
                        cnt_next = cnt_reg + FCW'(1);
                        nc_next  = nc_reg + NCW'(1);
                    end
                    if (last_weight)
                    begin
                        i_next = '0;
                        if (cnt_next > FCW'(1))
                        begin
                            state_next = S_SCAN_RD;
                        end
                        else
                        begin
                            state_next = S_ROOT_RD;
                        end
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_USE;
            end
            S_SCAN_USE:
            begin
                // track lightest and second lightest roots
                if (i_reg == FCW'(0))
                begin
                    wa_next = fr_w;
                    na_next = fr_n;
                    pa_next = i_reg;
                end
                else if (i_reg == FCW'(1))
                begin
                    if (fr_w <= wa_reg)
                    begin
                        wb_next = wa_reg;
                        nb_next = na_reg;
                        pb_next = pa_reg;
                        wa_next = fr_w;
                        na_next = fr_n;
                        pa_next = i_reg;
                    end
                    else
                    begin
                        wb_next = fr_w;
                        nb_next = fr_n;
                        pb_next = i_reg;
                    end
                end
                else if (fr_w < wa_reg)
                begin
                    wb_next = wa_reg;
                    nb_next = na_reg;
                    pb_next = pa_reg;
                    wa_next = fr_w;
                    na_next = fr_n;
                    pa_next = i_reg;
                end
                else if (fr_w < wb_reg)
                begin
                    wb_next = fr_w;
                    nb_next = fr_n;
                    pb_next = i_reg;
                end
                i_next = i_reg + FCW'(1);
                if (i_next == cnt_reg)
                begin
                    state_next = S_MERGE_WR;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_MERGE_WR:
            begin
                // new parent: lighter left, other right
                psum_next  = wa_reg + wb_reg;
                pid_next   = nc_reg[NIW-1:0];
                n_we       = 1'b1;
                n_wdata    = {psum_next, na_reg, nb_reg, 1'b0};
                nc_next    = nc_reg + NCW'(1);
                i_next     = '0;
                j_next     = '0;
                state_next = S_COMP_RD;
            end
            S_COMP_RD:
            begin
                state_next = S_COMP_USE;
            end
            S_COMP_USE:
            begin
                // keep every root but the two merged ones
                if ((i_reg != pa_reg) && (i_reg != pb_reg))
                begin
                    f_we    = 1'b1;
                    f_waddr = j_reg[FAW-1:0];
                    f_wdata = f_rdata;
                    j_next  = j_reg + FCW'(1);
                end
                i_next = i_reg + FCW'(1);
                if (i_next == cnt_reg)
                begin
                    state_next = S_COMP_END;
                end
                else
                begin
                    state_next = S_COMP_RD;
                end
            end
            S_COMP_END:
            begin
                // append parent at list end
                f_we     = 1'b1;
                f_waddr  = j_reg[FAW-1:0];
                f_wdata  = {psum_reg, pid_reg};
                cnt_next = j_reg + FCW'(1);
                i_next   = '0;
                if (cnt_next > FCW'(1))
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_ROOT_RD;
                end
            end
            S_ROOT_RD:
            begin
                f_raddr    = '0;
                state_next = S_ROOT_USE;
            end
            S_ROOT_USE:
            begin
                s_we       = 1'b1;
                s_waddr    = '0;
                s_wdata    = {fr_n, {CODE_W{1'b0}}, {LEN_W{1'b0}}};
                sp_next    = SPW'(1);
                state_next = S_POP_RD;
            end
            S_POP_RD:
            begin
                sp_next    = sp_reg - SPW'(1);
                state_next = S_POP_USE;
            end
            S_POP_USE:
            begin
                // node read addressed from the popped word
                n_raddr       = sr_node;
                cur_code_next = sr_code;
                cur_len_next  = sr_len;
                state_next    = S_NODE_USE;
            end
            S_NODE_USE:
            begin
                cur_w_next     = n_rdata[NODE_DW-NW +: WEIGHT_W];
                cur_left_next  = n_rdata[NIW+1 +: NIW];
                cur_right_next = n_rdata[1 +: NIW];
                if (nr_leaf || (cur_len_reg == LEN_MAX))
                begin
                    state_next = S_EMIT;
                end
                else if (sp_plus2 <= (SPW+1)'(SDEPTH))
                begin
                    push_l_next = 1'b0;
                    state_next  = S_PUSH_R;
                end
                else if (sp_reg == SPW'(0))
                begin
                    cnt_next   = '0;
                    nc_next    = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_POP_RD;
                end
            end
            S_EMIT:
            begin
                // hand a code word to the output register
                if (!ov_reg || !code_stall)
                begin
                    ov_next    = 1'b1;
                    ow_next    = cur_w_reg;
                    oc_next    = cur_code_reg;
                    ol_next    = cur_len_reg;
                    olast_next = (sp_reg == SPW'(0));
                    if (sp_reg == SPW'(0))
                    begin
                        cnt_next   = '0;
                        nc_next    = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_POP_RD;
                    end
                end
            end
            S_PUSH_R:
            begin
                // right child first so left pops first
                s_we    = 1'b1;
                sp_next = sp_reg + SPW'(1);
                if (!push_l_reg)
                begin
                    s_wdata     = {cur_right_reg, cur_code_reg[CODE_W-2:0], 1'b1,
                                   cur_len_reg + LEN_W'(1)};
                    push_l_next = 1'b1;
                end
                else
                begin
                    s_wdata     = {cur_left_reg, cur_code_reg[CODE_W-2:0], 1'b0,
                                   cur_len_reg + LEN_W'(1)};
                    push_l_next = 1'b0;
                    state_next  = S_POP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            push_l_reg <= 1'b0;
            cnt_reg    <= '0;
            nc_reg     <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            sp_reg     <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            push_l_reg <= push_l_next;
            cnt_reg    <= cnt_next;
            nc_reg     <= nc_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            sp_reg     <= sp_next;
            ov_reg     <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wa_reg        <= wa_next;
        wb_reg        <= wb_next;
        na_reg        <= na_next;
        nb_reg        <= nb_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        psum_reg      <= psum_next;
        pid_reg       <= pid_next;
        cur_code_reg  <= cur_code_next;
        cur_len_reg   <= cur_len_next;
        cur_left_reg  <= cur_left_next;
        cur_right_reg <= cur_right_next;
        cur_w_reg     <= cur_w_next;
        ow_reg        <= ow_next;
        oc_reg        <= oc_next;
        ol_reg        <= ol_next;
        olast_reg     <= olast_next;
    end

endmodule
